@@ sv/cscan_pkg.sv @@
// Shared types and constants for the C-SCAN request scheduler.
package cscan_pkg;

  // Queue geometry.
  localparam int QUEUE_DEPTH = 16;
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  // Field widths.
  localparam int SECTOR_W = 48;
  localparam int TAG_W    = 8;
  localparam int STATUS_W = 3;
  localparam int PEND_W   = 5;

  // Item kinds.
  localparam logic KIND_ADD      = 1'b0;
  localparam logic KIND_DISPATCH = 1'b1;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_ADDED      = 3'd0,
    ST_FULL       = 3'd1,
    ST_DISPATCHED = 3'd2,
    ST_WRAPPED    = 3'd3,
    ST_EMPTY      = 3'd4
  } status_t;

  // One queued request as stored in the entry memory.
  typedef struct packed {
    logic [SECTOR_W-1:0] sector;
    logic [TAG_W-1:0]    tag;
    logic                wr;
  } entry_t;

endpackage

@@ sv/cscan_ram.sv @@
// Generic single-clock RAM with one write port and one registered read port.
module cscan_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ sv/cscan_request_scheduler.sv @@
// Top level of the C-SCAN request scheduler: sorted request queue in a RAM.
//
//  Channel   Handshake              Fields
//  --------  ---------------------  ------------------------------------------------
//  item in   start, busy            kind, sector, tag, is_write
//  result    strobe (one cycle)     status, out_sector, out_tag, out_write,
//                                   pending_count
//
// An add walks the entry RAM down from the top and a dispatch walks it up from the
// bottom, walking it once more from the second entry when it wraps; the walk reads
// one entry per cycle.
// A full add or an empty dispatch gives its result in the next cycle.
// Reset (rst, synchronous) empties the queue and sets the head to sector zero.
// The receiver cannot stall: each result is shown for exactly one cycle.
module cscan_request_scheduler (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic                          kind,
  input  logic [cscan_pkg::SECTOR_W-1:0] sector,
  input  logic [cscan_pkg::TAG_W-1:0]    tag,
  input  logic                          is_write,
  output logic                          strobe,
  output logic [cscan_pkg::STATUS_W-1:0] status,
  output logic [cscan_pkg::SECTOR_W-1:0] out_sector,
  output logic [cscan_pkg::TAG_W-1:0]    out_tag,
  output logic                          out_write,
  output logic [cscan_pkg::PEND_W-1:0]   pending_count
);

  import cscan_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ADD_SCAN,
    S_ADD_PUT,
    S_DSP_SCAN
  } state_t;

  state_t state;

  // Queue bookkeeping.
  logic [CNT_W-1:0]    count;
  logic [SECTOR_W-1:0] head;

  // Accepted request.
  entry_t req;

  // Read stream over the entry RAM.
  logic [IDX_W-1:0] rd_idx;
  logic [CNT_W-1:0] rd_left;
  logic             dt_vld;
  logic [IDX_W-1:0] dt_idx;

  // Dispatch selection.
  logic   found;
  logic   wrapped;
  entry_t pick;
  entry_t first;

  // RAM ports.
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  entry_t           ram_wdata;
  entry_t           rd_entry;

  // Shared conditions.
  logic [IDX_W-1:0] last_idx;
  logic             add_shift;
  logic             ge_head;
  entry_t           wrap_entry;

  assign busy          = (state != S_IDLE);
  assign pending_count = PEND_W'(count);

  assign last_idx   = IDX_W'(count - CNT_W'(1));
  assign add_shift  = (req.sector < rd_entry.sector);
  assign ge_head    = (rd_entry.sector >= head);
  assign wrap_entry = (dt_idx == '0) ? rd_entry : first;

  cscan_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(QUEUE_DEPTH)
  ) u_entries (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(rd_idx),
    .rdata(rd_entry)
  );

  // RAM write port: shift entries up on add, down on dispatch, or place the new one.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = dt_idx;
    ram_wdata = rd_entry;
    unique case (state)
      S_ADD_SCAN: begin
        if (dt_vld) begin
          ram_we    = 1'b1;
          ram_waddr = IDX_W'(dt_idx + IDX_W'(1));
          ram_wdata = add_shift ? rd_entry : req;
        end
      end
      S_ADD_PUT: begin
        ram_we    = 1'b1;
        ram_waddr = '0;
        ram_wdata = req;
      end
      S_DSP_SCAN: begin
        if (dt_vld && found) begin
          ram_we    = 1'b1;
          ram_waddr = IDX_W'(dt_idx - IDX_W'(1));
        end
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // Sequencer, queue state and registered result.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      count   <= '0;
      head    <= '0;
      rd_left <= '0;
      dt_vld  <= 1'b0;
      found   <= 1'b0;
      strobe  <= 1'b0;
    end else begin
      strobe <= 1'b0;

      // Issue one read per cycle while reads remain; data returns next cycle.
      if (rd_left != '0) begin
        dt_vld  <= 1'b1;
        dt_idx  <= rd_idx;
        rd_left <= rd_left - CNT_W'(1);
        rd_idx  <= (state == S_ADD_SCAN) ? IDX_W'(rd_idx - IDX_W'(1))
                                         : IDX_W'(rd_idx + IDX_W'(1));
      end else begin
        dt_vld <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (start) begin
            req.sector <= sector;
            req.tag    <= tag;
            req.wr     <= is_write;
            found      <= 1'b0;
            wrapped    <= 1'b0;
            out_sector <= '0;
            out_tag    <= '0;
            out_write  <= 1'b0;
            if (kind == KIND_ADD) begin
              if (count == CNT_W'(QUEUE_DEPTH)) begin
                strobe <= 1'b1;
                status <= ST_FULL;
              end else if (count == '0) begin
                state <= S_ADD_PUT;
              end else begin
                rd_idx  <= last_idx;
                rd_left <= count;
                state   <= S_ADD_SCAN;
              end
            end else begin
              if (count == '0) begin
                strobe <= 1'b1;
                status <= ST_EMPTY;
              end else begin
                rd_idx  <= '0;
                rd_left <= count;
                state   <= S_DSP_SCAN;
              end
            end
          end
        end

        // Walk down from the top; the new item lands above the first entry not larger.
        S_ADD_SCAN: begin
          if (dt_vld) begin
            if (add_shift) begin
              if (dt_idx == '0) begin
                rd_left <= '0;
                state   <= S_ADD_PUT;
              end
            end else begin
              rd_left <= '0;
              count   <= count + CNT_W'(1);
              strobe  <= 1'b1;
              status  <= ST_ADDED;
              state   <= S_IDLE;
            end
          end
        end

        // The new item goes to the bottom of the queue.
        S_ADD_PUT: begin
          count  <= count + CNT_W'(1);
          strobe <= 1'b1;
          status <= ST_ADDED;
          state  <= S_IDLE;
        end

        // Walk up: find the first entry at or above the head (else wrap to the lowest), then close the gap.
        S_DSP_SCAN: begin
          if (dt_vld) begin
            if (dt_idx == '0) begin
              first <= rd_entry;
            end
            if (!found) begin
              if (ge_head) begin
                found <= 1'b1;
                pick  <= rd_entry;
                if (dt_idx == last_idx) begin
                  count      <= count - CNT_W'(1);
                  head       <= rd_entry.sector;
                  strobe     <= 1'b1;
                  status     <= ST_DISPATCHED;
                  out_sector <= rd_entry.sector;
                  out_tag    <= rd_entry.tag;
                  out_write  <= rd_entry.wr;
                  state      <= S_IDLE;
                end
              end else if (dt_idx == last_idx) begin
                // Nothing at or above the head: wrap to the lowest entry.
                if (count == CNT_W'(1)) begin
                  count      <= count - CNT_W'(1);
                  head       <= wrap_entry.sector;
                  strobe     <= 1'b1;
                  status     <= ST_WRAPPED;
                  out_sector <= wrap_entry.sector;
                  out_tag    <= wrap_entry.tag;
                  out_write  <= wrap_entry.wr;
                  state      <= S_IDLE;
                end else begin
                  found   <= 1'b1;
                  wrapped <= 1'b1;
                  pick    <= wrap_entry;
                  rd_idx  <= IDX_W'(1);
                  rd_left <= count - CNT_W'(1);
                end
              end
            end else if (dt_idx == last_idx) begin
              count      <= count - CNT_W'(1);
              head       <= pick.sector;
              strobe     <= 1'b1;
              status     <= wrapped ? ST_WRAPPED : ST_DISPATCHED;
              out_sector <= pick.sector;
              out_tag    <= pick.tag;
              out_write  <= pick.wr;
              state      <= S_IDLE;
            end
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
